// ===== src/cdn_pkg.sv =====
// Shared types, constants and helper functions for the complex dual-number ALU.
// Used by the front end, the queue, the divider and the back end.
`timescale 1ns / 1ps
package cdn_pkg;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int DQ     = 32;
    localparam int MW     = 97;

    localparam logic [31:0] MAX32 = 32'h7fff_ffff;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               dz;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] sr;
        logic signed [31:0] si;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic signed [31:0] tr;
        logic signed [31:0] ti;
    } t_item;

    typedef struct packed {
        logic [31:0] vr;
        logic [31:0] vi;
        logic [31:0] dr;
        logic [31:0] di;
        logic        sat;
    } t_res;

    typedef struct packed {
        logic [31:0] v;
        logic        sat;
    } t_sat;

    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [31:0] q;
        logic [63:0] rem;
    } t_quo;

    typedef struct packed {
        t_op                op;
        logic               dz;
        t_res               res;
        logic signed [31:0] sr;
        logic signed [31:0] si;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        logic signed [31:0] tr;
        logic signed [31:0] ti;
    } t_side1;

    typedef struct packed {
        t_op         op;
        logic        dz;
        t_res        res;
        logic        sat;
        logic [31:0] vr;
        logic [31:0] vi;
    } t_side2;

    function automatic t_sat f_sat(input logic signed [66:0] x);
        t_sat r;
        if (x > 67'sd2147483647) begin
            r = '{v: MAX32, sat: 1'b1};
        end else if (x < -67'sd2147483648) begin
            r = '{v: MIN32, sat: 1'b1};
        end else begin
            r = '{v: x[31:0], sat: 1'b0};
        end
        return r;
    endfunction

    // Rounds a quotient to nearest with ties upward, restores its sign and saturates.
    function automatic t_sat f_div_fin(input t_quo q, input logic [63:0] d);
        logic [64:0] rem2;
        logic [64:0] dd;
        logic        inc;
        logic [32:0] mag;
        t_sat        r;
        rem2 = {q.rem, 1'b0};
        dd   = {1'b0, d};
        inc  = q.neg ? (rem2 > dd) : (rem2 >= dd);
        mag  = {1'b0, q.q} + {32'd0, inc};
        if (q.ovf) begin
            r = q.neg ? '{v: MIN32, sat: 1'b1} : '{v: MAX32, sat: 1'b1};
        end else if (q.neg) begin
            if (mag > 33'h0_8000_0000) begin
                r = '{v: MIN32, sat: 1'b1};
            end else begin
                r = '{v: (~mag[31:0]) + 32'd1, sat: 1'b0};
            end
        end else if (mag > 33'h0_7fff_ffff) begin
            r = '{v: MAX32, sat: 1'b1};
        end else begin
            r = '{v: mag[31:0], sat: 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== src/cdn_front.sv =====
// Front end: takes input transfers, decodes the action and flags a zero divisor.
// Depends on cdn_pkg.
`timescale 1ns / 1ps
module cdn_front
    import cdn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_a_value_re,
    input  logic signed [31:0] i_a_value_im,
    input  logic signed [31:0] i_a_slope_re,
    input  logic signed [31:0] i_a_slope_im,
    input  logic signed [31:0] i_b_value_re,
    input  logic signed [31:0] i_b_value_im,
    input  logic signed [31:0] i_b_slope_re,
    input  logic signed [31:0] i_b_slope_im,
    input  logic               i_full,
    output logic               o_push,
    output t_item              o_item
);

    logic  r_vld;
    t_item r_item;
    t_item n_item;
    t_op   op;
    logic  accept;

    always_comb begin
        unique case (i_action)
            ACT_ADD: op = OP_ADD;
            ACT_SUB: op = OP_SUB;
            ACT_MUL: op = OP_MUL;
            ACT_DIV: op = OP_DIV;
            default: op = OP_ADD;
        endcase
    end

    always_comb begin
        n_item.op = op;
        n_item.dz = (op == OP_DIV) && (i_b_value_re == 32'sd0) && (i_b_value_im == 32'sd0);
        n_item.ar = i_a_value_re;
        n_item.ai = i_a_value_im;
        n_item.sr = i_a_slope_re;
        n_item.si = i_a_slope_im;
        n_item.br = i_b_value_re;
        n_item.bi = i_b_value_im;
        n_item.tr = i_b_slope_re;
        n_item.ti = i_b_slope_im;
    end

    assign o_push  = r_vld && !i_full;
    assign o_stall = r_vld && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept || (r_vld && !o_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== src/cdn_queue.sv =====
// Short queue of decoded items between the front end and the back end.
// Depends on cdn_pkg.
`timescale 1ns / 1ps
module cdn_queue
    import cdn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== src/cdn_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on cdn_pkg.
`timescale 1ns / 1ps
module cdn_div
    import cdn_pkg::*;
#(
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_d,
    input  logic [MW-1:0] i_m   [2],
    input  logic          i_neg [2],
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [63:0]   o_d,
    output t_quo          o_q   [2],
    output logic [SW-1:0] o_side
);

    logic          r_vld  [DQ+1];
    logic [63:0]   r_d    [DQ+1];
    logic [SW-1:0] r_side [DQ+1];
    logic [63:0]   r_rem  [DQ+1][2];
    logic [31:0]   r_low  [DQ+1][2];
    logic [31:0]   r_q    [DQ+1][2];
    logic          r_neg  [DQ+1][2];
    logic          r_ovf  [DQ+1][2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DQ; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= DQ; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]    <= i_d;
            r_side[0] <= i_side;
            for (int k = 1; k <= DQ; k++) begin
                r_d[k]    <= r_d[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [MW-33:0] hi;
        assign hi = i_m[l][MW-1:32];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0][l] <= hi[63:0];
                r_low[0][l] <= i_m[l][31:0];
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_neg[l];
                r_ovf[0][l] <= (hi >= {{(MW-96){1'b0}}, i_d});
            end
        end

        for (genvar k = 1; k <= DQ; k++) begin : g_step
            logic [64:0] cand;
            logic        ge;
            assign cand = {r_rem[k-1][l], r_low[k-1][l][31]};
            assign ge   = (cand >= {1'b0, r_d[k-1]});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k][l] <= ge ? 64'(cand - {1'b0, r_d[k-1]}) : cand[63:0];
                    r_low[k][l] <= {r_low[k-1][l][30:0], 1'b0};
                    r_q[k][l]   <= {r_q[k-1][l][30:0], ge};
                    r_neg[k][l] <= r_neg[k-1][l];
                    r_ovf[k][l] <= r_ovf[k-1][l];
                end
            end
        end

        assign o_q[l] = '{neg: r_neg[DQ][l], ovf: r_ovf[DQ][l], q: r_q[DQ][l],
                          rem: r_rem[DQ][l]};
    end

    assign o_valid = r_vld[DQ];
    assign o_d     = r_d[DQ];
    assign o_side  = r_side[DQ];

endmodule

// ===== src/cdn_back.sv =====
// Back end: products, sums, both divisions of the quotient rule and the output register.
// Depends on cdn_pkg and cdn_div.
`timescale 1ns / 1ps
module cdn_back
    import cdn_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_item      i_item,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output t_res       o_res,
    output logic [1:0] o_status
);

    localparam int WW = 66 - FRAC_BITS;
    localparam int HW = WW - 24;
    localparam int NW = 98;
    localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);

    logic adv;
    logic r_o_vld;
    assign adv   = !(r_o_vld && i_stall);
    assign o_pop = adv && i_q_valid;

    // Stage 1: products and add/subtract.
    logic               r1_vld;
    t_item              r1_it;
    t_res               r1_as;
    logic signed [63:0] r1_arbr, r1_aibi, r1_arbi, r1_aibr;
    logic signed [63:0] r1_artr, r1_aiti, r1_srbr, r1_sibi;
    logic signed [63:0] r1_arti, r1_aitr, r1_srbi, r1_sibr;
    logic signed [63:0] r1_brbr, r1_bibi;
    t_res               as_res;

    always_comb begin
        t_sat s0, s1, s2, s3;
        if (i_item.op == OP_SUB) begin
            s0 = f_sat(67'(i_item.ar) - 67'(i_item.br));
            s1 = f_sat(67'(i_item.ai) - 67'(i_item.bi));
            s2 = f_sat(67'(i_item.sr) - 67'(i_item.tr));
            s3 = f_sat(67'(i_item.si) - 67'(i_item.ti));
        end else begin
            s0 = f_sat(67'(i_item.ar) + 67'(i_item.br));
            s1 = f_sat(67'(i_item.ai) + 67'(i_item.bi));
            s2 = f_sat(67'(i_item.sr) + 67'(i_item.tr));
            s3 = f_sat(67'(i_item.si) + 67'(i_item.ti));
        end
        as_res = '{vr: s0.v, vi: s1.v, dr: s2.v, di: s3.v,
                   sat: s0.sat | s1.sat | s2.sat | s3.sat};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_it   <= i_item;
            r1_as   <= as_res;
            r1_arbr <= i_item.ar * i_item.br;
            r1_aibi <= i_item.ai * i_item.bi;
            r1_arbi <= i_item.ar * i_item.bi;
            r1_aibr <= i_item.ai * i_item.br;
            r1_artr <= i_item.ar * i_item.tr;
            r1_aiti <= i_item.ai * i_item.ti;
            r1_srbr <= i_item.sr * i_item.br;
            r1_sibi <= i_item.si * i_item.bi;
            r1_arti <= i_item.ar * i_item.ti;
            r1_aitr <= i_item.ai * i_item.tr;
            r1_srbi <= i_item.sr * i_item.bi;
            r1_sibr <= i_item.si * i_item.br;
            r1_brbr <= i_item.br * i_item.br;
            r1_bibi <= i_item.bi * i_item.bi;
        end
    end

    // Stage 2: sums of products.
    logic               r2_vld;
    t_item              r2_it;
    t_res               r2_as;
    logic signed [65:0] r2_mvr, r2_mvi, r2_mdr, r2_mdi;
    logic signed [64:0] r2_nvr, r2_nvi;
    logic [63:0]        r2_d;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_it  <= r1_it;
            r2_as  <= r1_as;
            r2_mvr <= 66'(r1_arbr) - 66'(r1_aibi);
            r2_mvi <= 66'(r1_arbi) + 66'(r1_aibr);
            r2_mdr <= 66'(r1_artr) - 66'(r1_aiti) + 66'(r1_srbr) - 66'(r1_sibi);
            r2_mdi <= 66'(r1_arti) + 66'(r1_aitr) + 66'(r1_srbi) + 66'(r1_sibr);
            r2_nvr <= 65'(r1_arbr) + 65'(r1_aibi);
            r2_nvi <= 65'(r1_aibr) - 65'(r1_arbi);
            r2_d   <= $unsigned(r1_brbr) + $unsigned(r1_bibi);
        end
    end

    // Multiply results and the first division's operands.
    t_side1      side1_in;
    logic [MW-1:0] m1 [2];
    logic          neg1 [2];

    always_comb begin
        t_sat        s0, s1, s2, s3;
        t_res        mul_res;
        logic [64:0] mag_r, mag_i;
        s0 = f_sat((67'(r2_mvr) + HALF) >>> FRAC_BITS);
        s1 = f_sat((67'(r2_mvi) + HALF) >>> FRAC_BITS);
        s2 = f_sat((67'(r2_mdr) + HALF) >>> FRAC_BITS);
        s3 = f_sat((67'(r2_mdi) + HALF) >>> FRAC_BITS);
        mul_res = '{vr: s0.v, vi: s1.v, dr: s2.v, di: s3.v,
                    sat: s0.sat | s1.sat | s2.sat | s3.sat};
        side1_in.op  = r2_it.op;
        side1_in.dz  = r2_it.dz;
        side1_in.res = (r2_it.op == OP_MUL) ? mul_res : r2_as;
        side1_in.sr  = r2_it.sr;
        side1_in.si  = r2_it.si;
        side1_in.br  = r2_it.br;
        side1_in.bi  = r2_it.bi;
        side1_in.tr  = r2_it.tr;
        side1_in.ti  = r2_it.ti;
        mag_r   = r2_nvr[64] ? 65'(-r2_nvr) : 65'(r2_nvr);
        mag_i   = r2_nvi[64] ? 65'(-r2_nvi) : 65'(r2_nvi);
        neg1[0] = r2_nvr[64];
        neg1[1] = r2_nvi[64];
        m1[0]   = {{(MW-65){1'b0}}, mag_r} << FRAC_BITS;
        m1[1]   = {{(MW-65){1'b0}}, mag_i} << FRAC_BITS;
    end

    logic                      d1_vld;
    logic [63:0]               d1_d;
    t_quo                      d1_q [2];
    logic [$bits(t_side1)-1:0] d1_side_bits;
    t_side1                    d1_side;

    cdn_div #(.SW($bits(t_side1))) u_div_value (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r2_vld),
        .i_d     (r2_d),
        .i_m     (m1),
        .i_neg   (neg1),
        .i_side  (side1_in),
        .o_valid (d1_vld),
        .o_d     (d1_d),
        .o_q     (d1_q),
        .o_side  (d1_side_bits)
    );
    assign d1_side = t_side1'(d1_side_bits);

    // Stage 4: quotient value.
    logic               r4_vld;
    t_side1             r4_s;
    logic [63:0]        r4_d;
    logic signed [31:0] r4_vr, r4_vi;
    logic               r4_sat;

    always_ff @(posedge i_clk) begin
        t_sat qr, qi;
        qr = f_div_fin(d1_q[0], d1_d);
        qi = f_div_fin(d1_q[1], d1_d);
        if (adv) begin
            r4_s   <= d1_side;
            r4_d   <= d1_d;
            r4_vr  <= qr.v;
            r4_vi  <= qi.v;
            r4_sat <= qr.sat | qi.sat;
        end
    end

    // Stage 5: products of the divisor slope and the quotient.
    logic               r5_vld;
    t_side1             r5_s;
    logic [63:0]        r5_d;
    logic signed [31:0] r5_vr, r5_vi;
    logic               r5_sat;
    logic signed [63:0] r5_trvr, r5_tivi, r5_trvi, r5_tivr;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_s    <= r4_s;
            r5_d    <= r4_d;
            r5_vr   <= r4_vr;
            r5_vi   <= r4_vi;
            r5_sat  <= r4_sat;
            r5_trvr <= r4_s.tr * r4_vr;
            r5_tivi <= r4_s.ti * r4_vi;
            r5_trvi <= r4_s.tr * r4_vi;
            r5_tivr <= r4_s.ti * r4_vr;
        end
    end

    // Stage 6: the slope numerator w, unsaturated.
    logic               r6_vld;
    t_side1             r6_s;
    logic [63:0]        r6_d;
    logic signed [31:0] r6_vr, r6_vi;
    logic               r6_sat;
    logic signed [WW-1:0] r6_wr, r6_wi;

    always_ff @(posedge i_clk) begin
        logic signed [66:0] rr, ri;
        rr = (67'(r5_trvr) - 67'(r5_tivi) + HALF) >>> FRAC_BITS;
        ri = (67'(r5_trvi) + 67'(r5_tivr) + HALF) >>> FRAC_BITS;
        if (adv) begin
            r6_s   <= r5_s;
            r6_d   <= r5_d;
            r6_vr  <= r5_vr;
            r6_vi  <= r5_vi;
            r6_sat <= r5_sat;
            r6_wr  <= WW'(67'(r5_s.sr) - rr);
            r6_wi  <= WW'(67'(r5_s.si) - ri);
        end
    end

    // Stage 7: w times the divisor, split into high and low partial products.
    logic               r7_vld;
    t_side1             r7_s;
    logic [63:0]        r7_d;
    logic signed [31:0] r7_vr, r7_vi;
    logic               r7_sat;
    logic signed [HW+31:0] r7_h_rr, r7_h_ii, r7_h_ir, r7_h_ri;
    logic signed [56:0]    r7_l_rr, r7_l_ii, r7_l_ir, r7_l_ri;

    always_ff @(posedge i_clk) begin
        logic signed [HW-1:0] wrh, wih;
        logic signed [24:0]   wrl, wil;
        wrh = r6_wr[WW-1:24];
        wih = r6_wi[WW-1:24];
        wrl = {1'b0, r6_wr[23:0]};
        wil = {1'b0, r6_wi[23:0]};
        if (adv) begin
            r7_s    <= r6_s;
            r7_d    <= r6_d;
            r7_vr   <= r6_vr;
            r7_vi   <= r6_vi;
            r7_sat  <= r6_sat;
            r7_h_rr <= wrh * r6_s.br;
            r7_h_ii <= wih * r6_s.bi;
            r7_h_ir <= wih * r6_s.br;
            r7_h_ri <= wrh * r6_s.bi;
            r7_l_rr <= wrl * r6_s.br;
            r7_l_ii <= wil * r6_s.bi;
            r7_l_ir <= wil * r6_s.br;
            r7_l_ri <= wrl * r6_s.bi;
        end
    end

    // Stage 8: second division's numerators.
    logic               r8_vld;
    t_side1             r8_s;
    logic [63:0]        r8_d;
    logic signed [31:0] r8_vr, r8_vi;
    logic               r8_sat;
    logic signed [NW-1:0] r8_nr, r8_ni;

    always_ff @(posedge i_clk) begin
        logic signed [NW-1:0] prr, pii, pir, pri;
        prr = (NW'(r7_h_rr) <<< 24) + NW'(r7_l_rr);
        pii = (NW'(r7_h_ii) <<< 24) + NW'(r7_l_ii);
        pir = (NW'(r7_h_ir) <<< 24) + NW'(r7_l_ir);
        pri = (NW'(r7_h_ri) <<< 24) + NW'(r7_l_ri);
        if (adv) begin
            r8_s   <= r7_s;
            r8_d   <= r7_d;
            r8_vr  <= r7_vr;
            r8_vi  <= r7_vi;
            r8_sat <= r7_sat;
            r8_nr  <= prr + pii;
            r8_ni  <= pir - pri;
        end
    end

    t_side2        side2_in;
    logic [MW-1:0] m2 [2];
    logic          neg2 [2];

    always_comb begin
        logic [NW-1:0] mag_r, mag_i;
        mag_r   = r8_nr[NW-1] ? NW'(-r8_nr) : NW'(r8_nr);
        mag_i   = r8_ni[NW-1] ? NW'(-r8_ni) : NW'(r8_ni);
        neg2[0] = r8_nr[NW-1];
        neg2[1] = r8_ni[NW-1];
        m2[0]   = MW'(mag_r << FRAC_BITS);
        m2[1]   = MW'(mag_i << FRAC_BITS);
        side2_in.op  = r8_s.op;
        side2_in.dz  = r8_s.dz;
        side2_in.res = r8_s.res;
        side2_in.sat = r8_sat;
        side2_in.vr  = r8_vr;
        side2_in.vi  = r8_vi;
    end

    logic                      d2_vld;
    logic [63:0]               d2_d;
    t_quo                      d2_q [2];
    logic [$bits(t_side2)-1:0] d2_side_bits;
    t_side2                    d2_side;

    cdn_div #(.SW($bits(t_side2))) u_div_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r8_vld),
        .i_d     (r8_d),
        .i_m     (m2),
        .i_neg   (neg2),
        .i_side  (side2_in),
        .o_valid (d2_vld),
        .o_d     (d2_d),
        .o_q     (d2_q),
        .o_side  (d2_side_bits)
    );
    assign d2_side = t_side2'(d2_side_bits);

    // Output register.
    t_res       r_o_res;
    logic [1:0] r_o_st;

    always_ff @(posedge i_clk) begin
        t_sat qr, qi;
        t_res res;
        logic [1:0] st;
        qr = f_div_fin(d2_q[0], d2_d);
        qi = f_div_fin(d2_q[1], d2_d);
        if (d2_side.op == OP_DIV) begin
            res = '{vr: d2_side.vr, vi: d2_side.vi, dr: qr.v, di: qi.v,
                    sat: d2_side.sat | qr.sat | qi.sat};
        end else begin
            res = d2_side.res;
        end
        if (d2_side.dz) begin
            res = '0;
            st  = ST_DZ;
        end else begin
            st = res.sat ? ST_SAT : ST_OK;
        end
        if (adv) begin
            r_o_res <= res;
            r_o_st  <= st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r1_vld  <= o_pop;
            r2_vld  <= r1_vld;
            r4_vld  <= d1_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r_o_vld <= d2_vld;
        end
    end

    assign o_valid  = r_o_vld;
    assign o_res    = r_o_res;
    assign o_status = r_o_st;

endmodule

// ===== src/complex_dual_number_alu_unit.sv =====
// Throughput: one item per cycle while i_stall does not hold the output; the back end is
// fully pipelined, including both 32-stage restoring dividers of the quotient rule.
// Reset is synchronous and active low; it empties the front register, the queue and
// the pipeline valid bits. Data registers are not reset.
`timescale 1ns / 1ps
module complex_dual_number_alu_unit
    import cdn_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_a_value_re,
    input  logic signed [31:0] i_a_value_im,
    input  logic signed [31:0] i_a_slope_re,
    input  logic signed [31:0] i_a_slope_im,
    input  logic signed [31:0] i_b_value_re,
    input  logic signed [31:0] i_b_value_im,
    input  logic signed [31:0] i_b_slope_re,
    input  logic signed [31:0] i_b_slope_im,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_r_value_re,
    output logic signed [31:0] o_r_value_im,
    output logic signed [31:0] o_r_slope_re,
    output logic signed [31:0] o_r_slope_im,
    output logic [1:0]         o_status
);

    logic  push, full, pop, q_valid;
    t_item f_item, q_item;
    t_res  res;

    cdn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_a_value_re (i_a_value_re),
        .i_a_value_im (i_a_value_im),
        .i_a_slope_re (i_a_slope_re),
        .i_a_slope_im (i_a_slope_im),
        .i_b_value_re (i_b_value_re),
        .i_b_value_im (i_b_value_im),
        .i_b_slope_re (i_b_slope_re),
        .i_b_slope_im (i_b_slope_im),
        .i_full       (full),
        .o_push       (push),
        .o_item       (f_item)
    );

    cdn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cdn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_res     (res),
        .o_status  (o_status)
    );

    assign o_r_value_re = res.vr;
    assign o_r_value_im = res.vi;
    assign o_r_slope_re = res.dr;
    assign o_r_slope_im = res.di;

endmodule

// ===== dv/tb_complex_dual_number_alu_unit.sv =====
// Self-checking testbench for complex_dual_number_alu_unit: a directed table, then random
// operand pairs, checked against an in-bench predictor with random idling on both sides.
// Depends on cdn_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_complex_dual_number_alu_unit;
    import cdn_pkg::*;

    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 1900;
    localparam int LIMIT     = 100000;
    localparam int DRAIN     = 150;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] ar, ai, sr, si, br, bi, tr, ti;
    } t_jet_pair;

    typedef struct packed {
        logic signed [31:0] vr, vi, dr, di;
        logic [1:0]         st;
    } t_jet_result;

    typedef struct packed {
        t_jet_pair   pair;
        logic        typed;
        t_jet_result want;
    } t_table_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_action = ACT_ADD;
    logic signed [31:0] i_a_value_re = '0, i_a_value_im = '0;
    logic signed [31:0] i_a_slope_re = '0, i_a_slope_im = '0;
    logic signed [31:0] i_b_value_re = '0, i_b_value_im = '0;
    logic signed [31:0] i_b_slope_re = '0, i_b_slope_im = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_r_value_re, o_r_value_im, o_r_slope_re, o_r_slope_im;
    logic [1:0]         o_status;

    t_jet_result pending_results[$];
    t_table_row  stim_table[$];
    logic        cur_typed = 1'b0;
    t_jet_result cur_want;
    int          mismatches = 0;
    int          cycle = 0;
    logic        quiet;

    complex_dual_number_alu_unit DUT (.*);

    always #2 i_clk = ~i_clk;

    assign quiet = (cycle > 600) && (cycle < 1400);

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] x,
                                                  inout logic hit);
        if (x > 128'sd2147483647) begin
            hit = 1'b1;
            return MAX32;
        end
        if (x < -128'sd2147483648) begin
            hit = 1'b1;
            return MIN32;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [127:0] round_frac(input logic signed [127:0] x);
        return (x + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic logic signed [127:0] div_nearest(input logic signed [127:0] x,
                                                       input logic [127:0] d);
        logic        neg;
        logic [127:0] m, q, r;
        neg = x < 0;
        m = neg ? -x : x;
        q = m / d;
        r = m % d;
        if (neg ? (r > d - r) : (r >= d - r)) q = q + 1;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_jet_result jet_arith(input t_jet_pair p);
        logic signed [127:0] ar, ai, sr, si, br, bi, tr, ti, vr, vi, wr, wi, d;
        t_jet_result res;
        logic hit;
        ar = p.ar; ai = p.ai; sr = p.sr; si = p.si;
        br = p.br; bi = p.bi; tr = p.tr; ti = p.ti;
        hit = 1'b0;
        res = '0;
        case (p.op)
            ACT_ADD: begin
                res.vr = clamp32(ar + br, hit); res.vi = clamp32(ai + bi, hit);
                res.dr = clamp32(sr + tr, hit); res.di = clamp32(si + ti, hit);
            end
            ACT_SUB: begin
                res.vr = clamp32(ar - br, hit); res.vi = clamp32(ai - bi, hit);
                res.dr = clamp32(sr - tr, hit); res.di = clamp32(si - ti, hit);
            end
            ACT_MUL: begin
                res.vr = clamp32(round_frac(ar * br - ai * bi), hit);
                res.vi = clamp32(round_frac(ar * bi + ai * br), hit);
                res.dr = clamp32(round_frac(ar * tr - ai * ti + sr * br - si * bi), hit);
                res.di = clamp32(round_frac(ar * ti + ai * tr + sr * bi + si * br), hit);
            end
            default: begin
                d = br * br + bi * bi;
                if (d == 0) begin
                    res.st = ST_DZ;
                    return res;
                end
                res.vr = clamp32(div_nearest((ar * br + ai * bi) <<< FRAC, d), hit);
                res.vi = clamp32(div_nearest((ai * br - ar * bi) <<< FRAC, d), hit);
                vr = res.vr;
                vi = res.vi;
                wr = sr - round_frac(tr * vr - ti * vi);
                wi = si - round_frac(tr * vi + ti * vr);
                res.dr = clamp32(div_nearest((wr * br + wi * bi) <<< FRAC, d), hit);
                res.di = clamp32(div_nearest((wi * br - wr * bi) <<< FRAC, d), hit);
            end
        endcase
        res.st = hit ? ST_SAT : ST_OK;
        return res;
    endfunction

    function automatic logic signed [31:0] pick_component();
        case ($urandom_range(0, 9))
            0: return MAX32;
            1: return MIN32;
            2: return '0;
            3, 4, 5: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h want %h (cycle %0d)", what, got, want, cycle);
    endtask

    task automatic add_row(input logic [1:0] op, input logic signed [31:0] ar, ai, sr, si,
                           br, bi, tr, ti, input logic typed,
                           input logic signed [31:0] vr, vi, dr, di, input logic [1:0] st);
        t_table_row row;
        row.pair = '{op, ar, ai, sr, si, br, bi, tr, ti};
        row.typed = typed;
        row.want = '{vr, vi, dr, di, st};
        stim_table.push_back(row);
    endtask

    task automatic send_pair(input t_jet_pair p);
        while (!quiet && $urandom_range(0, 99) < 12) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_action = p.op;
        i_a_value_re = p.ar; i_a_value_im = p.ai;
        i_a_slope_re = p.sr; i_a_slope_im = p.si;
        i_b_value_re = p.br; i_b_value_im = p.bi;
        i_b_slope_re = p.tr; i_b_slope_im = p.ti;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT) begin
            $display("complex_dual_number_alu_unit regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(0, 99) < 12);
    end

    always @(posedge i_clk) begin
        t_jet_pair   seen;
        t_jet_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                seen = '{i_action, i_a_value_re, i_a_value_im, i_a_slope_re, i_a_slope_im,
                         i_b_value_re, i_b_value_im, i_b_slope_re, i_b_slope_im};
                pending_results.push_back(cur_typed ? cur_want : jet_arith(seen));
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_r_value_re, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_r_value_re !== want.vr)
                        report_mismatch("value_re", o_r_value_re, want.vr);
                    if (o_r_value_im !== want.vi)
                        report_mismatch("value_im", o_r_value_im, want.vi);
                    if (o_r_slope_re !== want.dr)
                        report_mismatch("slope_re", o_r_slope_re, want.dr);
                    if (o_r_slope_im !== want.di)
                        report_mismatch("slope_im", o_r_slope_im, want.di);
                    if (o_status !== want.st)
                        report_mismatch("status", 32'(o_status), 32'(want.st));
                end
            end
        end
    end

    initial begin
        t_jet_pair p;
        add_row(ACT_ADD, ONE, 0, 0, 0, ONE, 0, 0, 0, 1, 2 * ONE, 0, 0, 0, ST_OK);
        add_row(ACT_ADD, MAX32, MAX32, MAX32, MAX32, ONE, ONE, ONE, ONE, 1,
                MAX32, MAX32, MAX32, MAX32, ST_SAT);
        add_row(ACT_SUB, MIN32, MIN32, MIN32, MIN32, ONE, ONE, ONE, ONE, 1,
                MIN32, MIN32, MIN32, MIN32, ST_SAT);
        add_row(ACT_SUB, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, ST_OK);
        add_row(ACT_MUL, ONE, 0, 0, 0, ONE, 0, 0, 0, 1, ONE, 0, 0, 0, ST_OK);
        add_row(ACT_MUL, 0, 0, 0, 0, MAX32, MIN32, MAX32, MIN32, 1, 0, 0, 0, 0, ST_OK);
        add_row(ACT_MUL, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, 0,
                0, 0, 0, 0, ST_OK);
        add_row(ACT_MUL, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, 0,
                0, 0, 0, 0, ST_OK);
        add_row(ACT_MUL, -ONE, ONE, 3, -5, ONE, -ONE, 7, 9, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_DIV, ONE, 0, 0, 0, ONE, 0, 0, 0, 1, ONE, 0, 0, 0, ST_OK);
        add_row(ACT_DIV, MAX32, MIN32, MAX32, MIN32, 0, 0, MAX32, MIN32, 1,
                0, 0, 0, 0, ST_DZ);
        add_row(ACT_DIV, MAX32, MAX32, MAX32, MAX32, 1, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_DIV, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, 0,
                0, 0, 0, 0, ST_OK);
        add_row(ACT_DIV, MAX32, 0, 0, 0, MIN32, 0, MAX32, MAX32, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_DIV, 3 * ONE, -ONE, ONE, 2, 0, 2 * ONE, -ONE, 5, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_DIV, 1, 0, -1, 0, 3, 0, 1, 1, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_DIV, -1, 0, 1, 0, 2, 0, 1, 1, 0, 0, 0, 0, 0, ST_OK);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_table[k]) begin
            cur_typed = stim_table[k].typed;
            cur_want = stim_table[k].want;
            send_pair(stim_table[k].pair);
        end
        cur_typed = 1'b0;
        repeat (N_RANDOM) begin
            p.op = 2'($urandom_range(0, 3));
            p.ar = pick_component(); p.ai = pick_component();
            p.sr = pick_component(); p.si = pick_component();
            p.br = pick_component(); p.bi = pick_component();
            p.tr = pick_component(); p.ti = pick_component();
            if (p.op == ACT_DIV && $urandom_range(0, 9) == 0) begin
                p.br = '0;
                p.bi = '0;
            end
            send_pair(p);
        end
        i_valid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("complex_dual_number_alu_unit regression: pass");
        end else begin
            $display("complex_dual_number_alu_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/cdn_pkg.sv
src/cdn_front.sv
src/cdn_queue.sv
src/cdn_div.sv
src/cdn_back.sv
src/complex_dual_number_alu_unit.sv
dv/tb_complex_dual_number_alu_unit.sv
